FILE: src/mprg_pkg.sv
// Shared types and constants for the multichannel pulse rate generator.
`default_nettype none

package mprg_pkg;

  // Register file and field widths
  localparam int REG_COUNT = 8;
  localparam int CH_W      = 3;
  localparam int CFG_IDX_W = 8;
  localparam int PPM_W     = 16;
  localparam int PER_W     = 10;
  localparam int WID_W     = 3;
  localparam int PPS_W     = 11;
  localparam int FT_W      = 10;
  localparam int STEP_W    = 4;

  // Period arithmetic: period = 1000 / (ppm / 60)
  localparam logic [PER_W-1:0] MS_PER_SECOND = 10'd1000;

  // ppm / 60 as (ppm * PPS_RECIP) >> PPS_SHIFT, exact for every 16-bit ppm
  localparam logic [PPM_W-1:0] PPS_RECIP = 16'd34953;
  localparam int               PPS_SHIFT = 21;
  localparam int               PROD_W    = 2 * PPM_W;

  typedef logic [PPM_W-1:0] ppm_t;
  typedef logic [PER_W-1:0] per_t;
  typedef logic [WID_W-1:0] wid_t;
  typedef logic [PPS_W-1:0] pps_t;

endpackage : mprg_pkg

`default_nettype wire

FILE: src/multichannel_pulse_rate_generator_core.sv
// Multichannel pulse rate generator: frame reload sequencer, divider and tick update.
// Flow: a normal tick goes from accept to S_TICK and the output register; a frame-load
//   tick (restart or frame start) first runs 1 multiply, 10 divide, 1 write per channel.
// Items: one tick at a time; in_stall is high while busy, and S_TICK waits on out_stall;
//   load ticks are slowed by the one shared multiply and the 10-step restoring divider.
// Reset: synchronous, active low; clears ppm registers, counters and frame position.
`default_nettype none

module multichannel_pulse_rate_generator_core
  import mprg_pkg::*;
#(
  parameter int NUM_CHANNELS = 8,
  parameter int PULSE_WIDTH  = 4,
  parameter int FRAME_TICKS  = 999
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // tick input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_restart,
  // result output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [REG_COUNT-1:0]      out_pulse_mask,
  output logic                      out_frame_start,
  // configuration write
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PPM_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WR,
    S_TICK
  } state_t;

  localparam logic [CH_W-1:0]   LAST_CH  = CH_W'(NUM_CHANNELS - 1);
  localparam logic [STEP_W-1:0] LAST_STP = STEP_W'(PER_W - 1);
  localparam wid_t              WID_LOAD = WID_W'((PULSE_WIDTH + 1) & 7);
  localparam wid_t              WID_RUN  = WID_W'(PULSE_WIDTH & 7);
  localparam logic [FT_W:0]     FT_END   = (FT_W + 1)'(FRAME_TICKS);

  state_t                state_r;
  logic [CH_W-1:0]       ch_r;
  logic [STEP_W-1:0]     step_r;
  logic                  load_r;
  pps_t                  pps_r;
  pps_t                  rem_r;
  per_t                  quo_r;
  per_t                  dvd_r;
  logic [FT_W-1:0]       ftick_r;
  logic                  out_valid_r;
  logic [REG_COUNT-1:0]  mask_r;
  logic                  fstart_r;

  ppm_t                  ppm_r    [REG_COUNT];
  per_t                  reload_r [REG_COUNT];
  per_t                  pcount_r [REG_COUNT];
  wid_t                  wcount_r [REG_COUNT];

  per_t                  pcount_nxt [REG_COUNT];
  wid_t                  wcount_nxt [REG_COUNT];
  logic [REG_COUNT-1:0]  mask_nxt;
  logic [FT_W-1:0]       ftick_nxt;
  logic [FT_W:0]         ftick_inc;

  logic [PROD_W-1:0]     prod;
  logic [PPS_W:0]        shifted;
  logic                  fits;
  pps_t                  rem_nxt;
  per_t                  period;
  logic                  out_free;

  assign in_stall        = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_pulse_mask  = mask_r;
  assign out_frame_start = fstart_r;
  assign out_free        = !out_valid_r || !out_stall;

  // Shared multiplier: ppm / 60 by reciprocal
  assign prod = PROD_W'(ppm_r[ch_r]) * PROD_W'(PPS_RECIP);

  // Shared divider step: shift in one dividend bit, subtract when it fits
  assign shifted = {rem_r, dvd_r[PER_W-1]};
  assign fits    = (shifted >= {1'b0, pps_r});
  always_comb begin
    if (fits) begin
      rem_nxt = PPS_W'(shifted - {1'b0, pps_r});
    end else begin
      rem_nxt = shifted[PPS_W-1:0];
    end
  end

  // Period from quotient: disabled below one pulse per second, floor at one tick
  always_comb begin
    if (pps_r == '0) begin
      period = '0;
    end else if (quo_r == '0) begin
      period = PER_W'(1);
    end else begin
      period = quo_r;
    end
  end

  // Tick update for every channel
  always_comb begin
    mask_nxt = '0;
    for (int i = 0; i < REG_COUNT; i++) begin
      pcount_nxt[i] = pcount_r[i];
      wcount_nxt[i] = wcount_r[i];
      if (reload_r[i] != '0) begin
        if (pcount_r[i] == '0 || wcount_r[i] != '0) begin
          mask_nxt[i] = 1'b1;
          if (wcount_r[i] != '0) begin
            wcount_nxt[i] = wcount_r[i] - WID_W'(1);
          end
          if (pcount_r[i] == '0) begin
            pcount_nxt[i] = reload_r[i];
            wcount_nxt[i] = WID_RUN;
          end
        end
        pcount_nxt[i] = pcount_nxt[i] - PER_W'(1);
      end
    end
  end

  // Frame position after this tick
  always_comb begin
    if (load_r) begin
      ftick_inc = (FT_W + 1)'(1);
    end else begin
      ftick_inc = {1'b0, ftick_r} + (FT_W + 1)'(1);
    end
    if (ftick_inc >= FT_END) begin
      ftick_nxt = '0;
    end else begin
      ftick_nxt = ftick_inc[FT_W-1:0];
    end
  end

  // Sequencer, channel state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      step_r      <= '0;
      load_r      <= 1'b0;
      ftick_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        ppm_r[i]    <= '0;
        reload_r[i] <= '0;
        pcount_r[i] <= '0;
        wcount_r[i] <= '0;
      end
    end else begin
      // take configuration writes; drop indexes beyond the register file
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
        ppm_r[cfg_index[CH_W-1:0]] <= cfg_data;
      end

      // release the result once taken; the tick step reloads it itself
      if (out_valid_r && !out_stall && (state_r != S_TICK)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            load_r <= in_restart || (ftick_r == '0);
            ch_r   <= '0;
            if (in_restart || (ftick_r == '0)) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_TICK;
            end
          end
        end
        S_MUL: begin
          pps_r   <= prod[PPS_SHIFT +: PPS_W];
          rem_r   <= '0;
          quo_r   <= '0;
          dvd_r   <= MS_PER_SECOND;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= {quo_r[PER_W-2:0], fits};
          dvd_r  <= {dvd_r[PER_W-2:0], 1'b0};
          step_r <= step_r + STEP_W'(1);
          if (step_r == LAST_STP) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          reload_r[ch_r] <= period;
          pcount_r[ch_r] <= period;
          wcount_r[ch_r] <= (period != '0) ? WID_LOAD : '0;
          if (ch_r == LAST_CH) begin
            state_r <= S_TICK;
          end else begin
            ch_r    <= ch_r + CH_W'(1);
            state_r <= S_MUL;
          end
        end
        S_TICK: begin
          // hold until the output register is free
          if (out_free) begin
            for (int i = 0; i < REG_COUNT; i++) begin
              pcount_r[i] <= pcount_nxt[i];
              wcount_r[i] <= wcount_nxt[i];
            end
            ftick_r     <= ftick_nxt;
            mask_r      <= mask_nxt;
            fstart_r    <= load_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule : multichannel_pulse_rate_generator_core

`default_nettype wire

FILE: src/mprg_checker.sv
// Port-level checker for the pulse rate generator, bound to the top level.
`default_nettype none

module mprg_checker
  import mprg_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [REG_COUNT-1:0] out_pulse_mask,
  input wire logic                 out_frame_start
);

  // Block one item at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on the cycle after an accept");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pulse_mask)
      && $stable(out_frame_start))
    else $error("stalled result changed");

  // Keep unused channels quiet
  a_unused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pulse_mask >> NUM_CHANNELS) == '0))
    else $error("pulse on a channel beyond NUM_CHANNELS");

  // Drop output valid in reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : mprg_checker

bind multichannel_pulse_rate_generator_core mprg_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_mprg_checker (.*);

`default_nettype wire
